/* rtl/core/dats_pkg.sv */
// shared constants, types and register codes for the adc-to-stroke core
// no dependencies; every other file in rtl/core refers to this package by scoped names
package dats_pkg;

  // converter full scale; codes at or above it are pinned one below
  localparam int AdcFullScale = 4095;

  // field widths
  localparam int CodeW   = 12;
  localparam int FrW     = 16;
  localparam int GainW   = 24;
  localparam int OffW    = 17;
  localparam int MaxW    = 16;
  localparam int StrokeW = 16;

  // fixed-point positions
  localparam int ResFrac  = 8;   // resistance in q.8 ohms
  localparam int GainFrac = 22;  // gain*r is scaled down by 2^22

  // derived widths
  localparam int FsW       = $clog2(AdcFullScale + 1);
  localparam int CmpW      = (FsW > CodeW) ? FsW : CodeW;
  localparam int RemW      = FsW;
  localparam int ProdW     = FrW + CodeW;
  localparam int QuoW      = ProdW + ResFrac;
  localparam int Bps       = 4;  // quotient bits per divider stage
  localparam int DivStages = (QuoW + Bps - 1) / Bps;
  localparam int PadW      = DivStages * Bps;
  localparam int RlW       = GainFrac;
  localparam int RhW       = QuoW - GainFrac;
  localparam int HiW       = GainW + RhW;
  localparam int LoW       = GainW + RlW;
  localparam int SumW      = HiW + 2;

  // register port
  localparam int AddrW = 4;
  localparam int DataW = 32;

  typedef enum logic [1:0] {
    RegFixedRes  = 2'd0,
    RegGain      = 2'd1,
    RegOffset    = 2'd2,
    RegMaxStroke = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    ClampNone = 2'd0,
    ClampZero = 2'd1,
    ClampMax  = 2'd2
  } clamp_t;

  localparam logic [FrW-1:0]   FixedResReset  = FrW'(1000);
  localparam logic [GainW-1:0] GainReset      = GainW'(450158);
  localparam logic [OffW-1:0]  OffsetReset    = OffW'(-14633);
  localparam logic [MaxW-1:0]  MaxStrokeReset = MaxW'(55296);

  typedef struct packed {
    logic [FrW-1:0]   fixed_resistance;
    logic [GainW-1:0] gain;
    logic [OffW-1:0]  offset;
    logic [MaxW-1:0]  max_stroke;
  } cfg_t;

  typedef struct packed {
    logic [QuoW-1:0] quo;
    logic            zero;
  } div_out_t;

endpackage

/* rtl/core/dats_cfg.sv */
// apb-style register file holding the calibration registers
// depends on dats_pkg
module dats_cfg (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dats_pkg::AddrW-1:0] paddr,
  input  logic [dats_pkg::DataW-1:0] pwdata,
  output logic [dats_pkg::DataW-1:0] prdata,
  output logic                       pready,
  output dats_pkg::cfg_t             cfg
);

  dats_pkg::reg_idx_t idx;
  logic               wr;

  assign idx    = dats_pkg::reg_idx_t'(paddr[dats_pkg::AddrW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.fixed_resistance <= dats_pkg::FixedResReset;
      cfg.gain             <= dats_pkg::GainReset;
      cfg.offset           <= dats_pkg::OffsetReset;
      cfg.max_stroke       <= dats_pkg::MaxStrokeReset;
    end else if (wr) begin
      case (idx)
        dats_pkg::RegFixedRes:  cfg.fixed_resistance <= pwdata[dats_pkg::FrW-1:0];
        dats_pkg::RegGain:      cfg.gain             <= pwdata[dats_pkg::GainW-1:0];
        dats_pkg::RegOffset:    cfg.offset           <= pwdata[dats_pkg::OffW-1:0];
        dats_pkg::RegMaxStroke: cfg.max_stroke       <= pwdata[dats_pkg::MaxW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dats_pkg::RegFixedRes:  prdata = dats_pkg::DataW'(cfg.fixed_resistance);
      dats_pkg::RegGain:      prdata = dats_pkg::DataW'(cfg.gain);
      dats_pkg::RegOffset:    prdata = {{(dats_pkg::DataW - dats_pkg::OffW)
                                         {cfg.offset[dats_pkg::OffW-1]}}, cfg.offset};
      dats_pkg::RegMaxStroke: prdata = dats_pkg::DataW'(cfg.max_stroke);
      default:                prdata = '0;
    endcase
  end

endmodule

/* rtl/core/dats_div.sv */
// input conditioning and pipelined restoring divider for the sensor resistance
// depends on dats_pkg; one prep stage then DivStages stages of Bps quotient bits each
module dats_div (
  input  logic                       clk,
  input  logic                       rst,
  input  dats_pkg::cfg_t             cfg,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [dats_pkg::CodeW-1:0] adc_code,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dats_pkg::div_out_t         out_data
);

  localparam int NSt = dats_pkg::DivStages + 1;

  typedef struct packed {
    logic [dats_pkg::RemW-1:0] rem;
    logic [dats_pkg::PadW-1:0] acc;
  } div_st_t;

  logic                      v    [NSt];
  logic                      en   [NSt];
  logic [dats_pkg::RemW-1:0] rem  [NSt];
  logic [dats_pkg::PadW-1:0] acc  [NSt];
  logic [dats_pkg::RemW-1:0] dvs  [NSt];
  logic                      zero [NSt];
  div_st_t                   nxt  [NSt];

  logic [dats_pkg::CmpW-1:0]  code_ext;
  logic [dats_pkg::CodeW-1:0] code_c;
  logic [dats_pkg::RemW-1:0]  dvs_in;
  logic [dats_pkg::ProdW-1:0] prod_in;

  // Bps steps of shift, compare and subtract
  function automatic div_st_t div_steps(input logic [dats_pkg::RemW-1:0] rem_i,
                                        input logic [dats_pkg::PadW-1:0] acc_i,
                                        input logic [dats_pkg::RemW-1:0] dvs_i);
    logic [dats_pkg::RemW:0]   t;
    logic [dats_pkg::RemW-1:0] r;
    logic [dats_pkg::PadW-1:0] a;
    div_st_t                   res;
    r = rem_i;
    a = acc_i;
    for (int j = 0; j < dats_pkg::Bps; j++) begin
      t = {r, a[dats_pkg::PadW-1]};
      a = {a[dats_pkg::PadW-2:0], 1'b0};
      if (t >= {1'b0, dvs_i}) begin
        r    = dats_pkg::RemW'(t - {1'b0, dvs_i});
        a[0] = 1'b1;
      end else begin
        r = dats_pkg::RemW'(t);
      end
    end
    res.rem = r;
    res.acc = a;
    return res;
  endfunction

  // full-scale pin, divisor and numerator product
  always_comb begin
    code_ext = dats_pkg::CmpW'(adc_code);
    if (code_ext >= dats_pkg::CmpW'(dats_pkg::AdcFullScale)) begin
      code_c = dats_pkg::CodeW'(dats_pkg::AdcFullScale - 1);
    end else begin
      code_c = adc_code;
    end
    dvs_in  = dats_pkg::RemW'(dats_pkg::CmpW'(dats_pkg::AdcFullScale)
                              - dats_pkg::CmpW'(code_c));
    prod_in = cfg.fixed_resistance * code_c;
  end

  always_comb begin
    nxt[0] = '0;
    for (int k = 1; k < NSt; k++) begin
      nxt[k] = div_steps(rem[k-1], acc[k-1], dvs[k-1]);
    end
  end

  // per-stage enable: a stage moves when empty or when the next one moves
  always_comb begin
    en[NSt-1] = !v[NSt-1] || out_ready;
    for (int k = NSt - 2; k >= 0; k--) begin
      en[k] = !v[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NSt; k++) begin
        v[k] <= 1'b0;
      end
    end else begin
      if (en[0]) begin
        v[0] <= in_valid;
      end
      for (int k = 1; k < NSt; k++) begin
        if (en[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0]  <= '0;
      acc[0]  <= dats_pkg::PadW'({prod_in, {dats_pkg::ResFrac{1'b0}}});
      dvs[0]  <= dvs_in;
      zero[0] <= (code_c == '0);
    end
    for (int k = 1; k < NSt; k++) begin
      if (en[k]) begin
        rem[k]  <= nxt[k].rem;
        acc[k]  <= nxt[k].acc;
        dvs[k]  <= dvs[k-1];
        zero[k] <= zero[k-1];
      end
    end
  end

  assign in_ready      = en[0];
  assign out_valid     = v[NSt-1];
  assign out_data.quo  = acc[NSt-1][dats_pkg::QuoW-1:0];
  assign out_data.zero = zero[NSt-1];

endmodule

/* rtl/core/dats_scale.sv */
// gain multiply, offset add and clamp stages producing the stroke
// depends on dats_pkg; three register stages, the last one is the output register
module dats_scale (
  input  logic                         clk,
  input  logic                         rst,
  input  dats_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  dats_pkg::div_out_t           in_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dats_pkg::StrokeW-1:0] stroke,
  output logic [1:0]                   clamp_status
);

  logic m_valid, a_valid, c_valid;
  logic en_m, en_a, en_c;

  logic [dats_pkg::HiW-1:0]  m_hi;
  logic [dats_pkg::LoW-1:0]  m_lo;
  logic                      m_zero;
  logic [dats_pkg::SumW-1:0] a_sum;
  logic [dats_pkg::SumW-1:0] a_sum_next;
  logic                      a_zero;
  logic [dats_pkg::StrokeW-1:0] c_stroke;
  logic [dats_pkg::StrokeW-1:0] c_stroke_next;
  dats_pkg::clamp_t             c_status;
  dats_pkg::clamp_t             c_status_next;

  logic [dats_pkg::RhW-1:0] rh;
  logic [dats_pkg::RlW-1:0] rl;
  logic                     neg, over;

  assign en_c     = !c_valid || out_ready;
  assign en_a     = !a_valid || en_c;
  assign en_m     = !m_valid || en_a;
  assign in_ready = en_m;

  assign rh = in_data.quo[dats_pkg::QuoW-1:dats_pkg::GainFrac];
  assign rl = in_data.quo[dats_pkg::GainFrac-1:0];

  // floor(gain*r/2^22) = gain*rh + floor(gain*rl/2^22), then the signed offset
  assign a_sum_next = dats_pkg::SumW'(m_hi)
                    + dats_pkg::SumW'(m_lo[dats_pkg::LoW-1:dats_pkg::GainFrac])
                    + {{(dats_pkg::SumW - dats_pkg::OffW){cfg.offset[dats_pkg::OffW-1]}},
                       cfg.offset};

  assign neg  = a_sum[dats_pkg::SumW-1];
  assign over = a_sum[dats_pkg::SumW-2:0] > (dats_pkg::SumW - 1)'(cfg.max_stroke);

  always_comb begin
    if (a_zero) begin
      c_stroke_next = '0;
      c_status_next = dats_pkg::ClampNone;
    end else if (neg) begin
      c_stroke_next = '0;
      c_status_next = dats_pkg::ClampZero;
    end else if (over) begin
      c_stroke_next = dats_pkg::StrokeW'(cfg.max_stroke);
      c_status_next = dats_pkg::ClampMax;
    end else begin
      c_stroke_next = a_sum[dats_pkg::StrokeW-1:0];
      c_status_next = dats_pkg::ClampNone;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
      a_valid <= 1'b0;
      c_valid <= 1'b0;
    end else begin
      if (en_m) m_valid <= in_valid;
      if (en_a) a_valid <= m_valid;
      if (en_c) c_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_m) begin
      m_hi   <= cfg.gain * rh;
      m_lo   <= cfg.gain * rl;
      m_zero <= in_data.zero;
    end
    if (en_a) begin
      a_sum  <= a_sum_next;
      a_zero <= m_zero;
    end
    if (en_c) begin
      c_stroke <= c_stroke_next;
      c_status <= c_status_next;
    end
  end

  assign out_valid    = c_valid;
  assign stroke       = c_stroke;
  assign clamp_status = c_status;

endmodule

/* rtl/core/divider_adc_to_stroke_core.sv */
// top level of the adc-to-stroke core: register file, divider pipeline, scale pipeline
// depends on dats_pkg, dats_cfg, dats_div and dats_scale
//
// Converts a 12-bit converter code taken from a potentiometer in a voltage
// divider into a stroke length in q.10 millimetres. Codes at full scale are
// pinned one below, code zero gives stroke 0 with no clamp flag; otherwise the
// sensor resistance floor(fixed_resistance*code*256/(4095-code)) is scaled by
// the q2.22 gain (divided by 2^22), the signed offset is added and the result
// is clamped to 0..max_stroke, with clamp_status telling which bound hit.
// Throughput is one item per clock unless the output stalls; the path holds 13
// register stages: one conditioning stage, nine restoring-divider stages of four
// quotient bits each, then multiply, add and clamp stages. Each stage stalls only
// when it is full and the stage after it is stalled, so holes in the stream are
// squeezed out under backpressure. Calibration registers sit on the apb port at
// byte addresses 0 (resistor), 4 (gain), 8 (offset) and 12 (max stroke); the user
// must write them only while idle, and the block itself does not enforce this.
module divider_adc_to_stroke_core (
  input  logic                         clk,
  input  logic                         rst,
  // register port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [dats_pkg::AddrW-1:0]   paddr,
  input  logic [dats_pkg::DataW-1:0]   pwdata,
  output logic [dats_pkg::DataW-1:0]   prdata,
  output logic                         pready,
  // sample input
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [dats_pkg::CodeW-1:0]   adc_code,
  // stroke output
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dats_pkg::StrokeW-1:0] stroke,
  output logic [1:0]                   clamp_status
);

  dats_pkg::cfg_t     cfg;
  dats_pkg::div_out_t div_data;
  logic               div_valid;
  logic               div_ready;

  // calibration registers
  dats_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // code conditioning and resistance division
  dats_div u_div (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .adc_code  (adc_code),
    .out_valid (div_valid),
    .out_ready (div_ready),
    .out_data  (div_data)
  );

  // gain, offset and clamp; holds the output register
  dats_scale u_scale (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (div_valid),
    .in_ready     (div_ready),
    .in_data      (div_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stroke       (stroke),
    .clamp_status (clamp_status)
  );

endmodule

/* rtl/core/dats_checker.sv */
// port-level checks for the adc-to-stroke core, bound to the top level
// depends on dats_pkg and divider_adc_to_stroke_core
module dats_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [dats_pkg::StrokeW-1:0] stroke,
  input logic [1:0]                   clamp_status
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(stroke) && $stable(clamp_status))
    else $error("output item changed while stalled");

  // status carries one of the three defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> clamp_status == dats_pkg::ClampNone || clamp_status == dats_pkg::ClampZero
                  || clamp_status == dats_pkg::ClampMax)
    else $error("undefined clamp status");

  // clamped to zero means zero stroke
  a_zero_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && clamp_status == dats_pkg::ClampZero |-> stroke == '0)
    else $error("zero clamp with nonzero stroke");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind divider_adc_to_stroke_core dats_checker u_dats_checker (.*);

/* test/dats_stroke_checker.sv */
`timescale 1ns / 100ps
// checker for the adc-to-stroke core: follows the calibration writes, predicts the stroke
// of every accepted sample and compares it with the core's results; depends on dats_pkg
module dats_stroke_checker (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic                         pready,
  input  logic [dats_pkg::AddrW-1:0]   paddr,
  input  logic [dats_pkg::DataW-1:0]   pwdata,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [dats_pkg::CodeW-1:0]   adc_code,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [dats_pkg::StrokeW-1:0] stroke,
  input  logic [1:0]                   clamp_status,
  output int                           mismatches,
  output int                           outstanding
);
  import dats_pkg::*;

  typedef struct packed {
    logic [StrokeW-1:0] stroke;
    clamp_t             clamp;
  } stroke_res_t;

  cfg_t        cal;
  stroke_res_t stroke_q[$];
  int          err_cnt = 0;

  // resistance in q.8 ohms, scaled by the gain, offset added, then clamped
  function automatic stroke_res_t predict_item(input cfg_t c, input logic [CodeW-1:0] raw);
    logic [CodeW-1:0] code;
    logic [63:0]      res;
    logic [63:0]      scaled;
    longint           s;
    stroke_res_t      r;
    code = (int'(raw) >= AdcFullScale) ? CodeW'(AdcFullScale - 1) : raw;
    r.stroke = '0;
    r.clamp = ClampNone;
    if (code != '0) begin
      res = ((64'(c.fixed_resistance) * 64'(code)) << ResFrac)
            / 64'(AdcFullScale - int'(code));
      scaled = (64'(c.gain) * res) >> GainFrac;
      s = longint'(scaled) + longint'($signed(c.offset));
      if (s < 0) begin
        r.clamp = ClampZero;
      end else if (s > longint'(c.max_stroke)) begin
        r.stroke = c.max_stroke;
        r.clamp = ClampMax;
      end else begin
        r.stroke = StrokeW'(s);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    stroke_res_t want;
    if (rst) begin
      cal = '{fixed_resistance: FixedResReset, gain: GainReset,
              offset: OffsetReset, max_stroke: MaxStrokeReset};
      stroke_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[AddrW-1:2]))
          RegFixedRes:  cal.fixed_resistance = pwdata[FrW-1:0];
          RegGain:      cal.gain = pwdata[GainW-1:0];
          RegOffset:    cal.offset = pwdata[OffW-1:0];
          RegMaxStroke: cal.max_stroke = pwdata[MaxW-1:0];
          default: ;
        endcase
      end
      // results first, so a sample taken in the same cycle queues behind them
      if (out_valid && out_ready) begin
        if (stroke_q.size() == 0) begin
          $error("unexpected result: stroke %0d clamp_status %0d", stroke, clamp_status);
          err_cnt++;
        end else begin
          want = stroke_q.pop_front();
          if (stroke !== want.stroke) begin
            $error("stroke: expected %0d, got %0d", want.stroke, stroke);
            err_cnt++;
          end
          if (clamp_status !== want.clamp) begin
            $error("clamp_status: expected %0d, got %0d", want.clamp, clamp_status);
            err_cnt++;
          end
        end
      end
      if (in_valid && in_ready) stroke_q.push_back(predict_item(cal, adc_code));
    end
    mismatches <= err_cnt;
    outstanding <= stroke_q.size();
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// testbench top for divider_adc_to_stroke_core: clock, reset, calibration writes, sample
// stimulus and output backpressure; depends on dats_pkg, the core and dats_stroke_checker
module tb;
  import dats_pkg::*;

  localparam int WatchdogLimit = 4000;  // cycles without progress before giving up
  localparam int HoldCycles    = 400;   // long output hold-off, well past the pipe depth
  localparam int DrainCycles   = 40;    // settle time at the end, well past the pipe depth
  localparam int RandPhases    = 10;
  localparam int PhaseItems    = 100;

  logic                 clk;
  logic                 rst;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [AddrW-1:0]     paddr;
  logic [DataW-1:0]     pwdata;
  logic [DataW-1:0]     prdata;
  logic                 pready;
  logic                 in_valid;
  logic                 in_ready;
  logic [CodeW-1:0]     adc_code;
  logic                 out_valid;
  logic                 out_ready;
  logic [StrokeW-1:0]   stroke;
  logic [1:0]           clamp_status;

  int mismatches;
  int outstanding;
  int send_gap_max = 0;
  int recv_gap_max = 0;
  bit hold_req = 1'b0;
  int stall_cnt = 0;
  int n_items = 0;
  int n_settings = 0;

  // edge codes under the reset calibration: zero, one, mid scale, alternating
  // bit patterns, one below full scale and full scale itself
  logic [CodeW-1:0] corner_codes [13] = '{
    12'd0, 12'd1, 12'd2, 12'd100, 12'h555, 12'h7ff, 12'h800,
    12'haaa, 12'd3000, 12'd4000, 12'd4093, 12'd4094, 12'd4095
  };

  divider_adc_to_stroke_core i_dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .adc_code     (adc_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stroke       (stroke),
    .clamp_status (clamp_status)
  );

  dats_stroke_checker i_check (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .adc_code     (adc_code),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stroke       (stroke),
    .clamp_status (clamp_status),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // progress watchdog: only counts while something is offered or still owed
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (!in_valid && outstanding == 0)) begin
      stall_cnt <= 0;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
    if (stall_cnt >= WatchdogLimit) begin
      $display("watchdog: %0d cycles without progress, %0d results owed",
               stall_cnt, outstanding);
      $display("divider_adc_to_stroke_core verification failed");
      $finish;
    end
  end

  // apb write: setup cycle, then access cycle until pready
  task automatic write_reg(input reg_idx_t idx, input logic [DataW-1:0] value);
    @(negedge clk) begin
      psel = 1'b1;
      penable = 1'b0;
      pwrite = 1'b1;
      paddr = AddrW'({idx, 2'b00});
      pwdata = value;
    end
    @(negedge clk) penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk) begin
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
    end
  endtask

  task automatic write_cal(input logic [FrW-1:0] fr, input logic [GainW-1:0] g,
                           input logic [OffW-1:0] off, input logic [MaxW-1:0] mx);
    write_reg(RegFixedRes, DataW'(fr));
    write_reg(RegGain, DataW'(g));
    write_reg(RegOffset, DataW'(off));
    write_reg(RegMaxStroke, DataW'(mx));
    n_settings++;
  endtask

  // calibration draw: mostly sensible ranges, with the register extremes mixed in
  task automatic random_cal();
    logic [FrW-1:0]   fr;
    logic [GainW-1:0] g;
    logic [OffW-1:0]  off;
    logic [MaxW-1:0]  mx;
    case ($urandom_range(0, 9))
      0:       fr = FrW'(1);
      1:       fr = '1;
      2, 3:    fr = FrW'($urandom);
      default: fr = FrW'($urandom_range(100, 5000));
    endcase
    case ($urandom_range(0, 9))
      0:       g = '0;
      1:       g = '1;
      2, 3:    g = GainW'($urandom);
      default: g = GainW'($urandom_range(1 << 17, 1 << 20));
    endcase
    case ($urandom_range(0, 9))
      0:       off = {1'b1, {(OffW-1){1'b0}}};  // most negative
      1:       off = {1'b0, {(OffW-1){1'b1}}};  // most positive
      2, 3:    off = OffW'($urandom);
      default: off = OffW'($urandom_range(0, 40000) - 20000);
    endcase
    case ($urandom_range(0, 9))
      0:       mx = '0;
      1:       mx = '1;
      default: mx = MaxW'($urandom);
    endcase
    write_cal(fr, g, off, mx);
  endtask

  // one item: optional idle gap, then hold valid until in_ready at an edge
  task automatic send_code(input logic [CodeW-1:0] code);
    int gap;
    gap = (send_gap_max > 0) ? $urandom_range(0, send_gap_max) : 0;
    if (gap > 0) begin
      @(negedge clk) in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk) begin
      in_valid = 1'b1;
      adc_code = code;
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  // stop offering and wait until every owed result has come back
  task automatic drain();
    @(negedge clk) in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  function automatic logic [CodeW-1:0] random_code();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return CodeW'(1);
      2:       return CodeW'(AdcFullScale - 1);
      3:       return '1;
      default: return CodeW'($urandom_range(0, (1 << CodeW) - 1));
    endcase
  endfunction

  // receiver: random stall per item, plus one long hold-off on request
  initial begin : receiver
    int stall;
    out_ready = 1'b0;
    forever begin
      if (hold_req) begin
        @(negedge clk) out_ready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
        hold_req = 1'b0;
      end
      stall = (recv_gap_max > 0) ? $urandom_range(0, recv_gap_max) : 0;
      if (stall > 0) begin
        @(negedge clk) out_ready = 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk) out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    adc_code = '0;
    repeat (9) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    // directed part, with idling on both sides
    send_gap_max = 14;
    recv_gap_max = 14;
    foreach (corner_codes[i]) send_code(corner_codes[i]);

    // zero resistor register: stroke is just the offset, clamped
    drain();
    write_cal(16'd0, 24'd450158, 17'd5000, 16'd65535);
    send_code(12'd1);
    send_code(12'd2048);
    send_code(12'd4095);
    drain();
    write_reg(RegOffset, DataW'(-17'sd3000));
    send_code(12'd2048);

    // max stroke of zero: negative sum still reports clamp to zero
    drain();
    write_cal(16'd1000, 24'd450158, -17'sd100, 16'd0);
    send_code(12'd1);
    send_code(12'd2048);
    drain();
    write_reg(RegOffset, DataW'(17'd100));
    send_code(12'd2048);
    send_code(12'd0);  // zero code ignores the offset

    // all registers at their top values, then at their bottom values with the resistor at one
    drain();
    write_cal('1, '1, {1'b0, {(OffW-1){1'b1}}}, '1);
    send_code(12'd1);
    send_code(12'd4094);
    send_code(12'd0);
    drain();
    write_cal(16'd1, 24'd0, {1'b1, {(OffW-1){1'b0}}}, 16'd0);
    send_code(12'd4094);

    // random phases; each one changes the calibration and the idling mix
    for (int ph = 0; ph < RandPhases; ph++) begin
      drain();
      random_cal();
      send_gap_max = (ph % 2 == 1) ? 14 : 0;
      recv_gap_max = (ph % 4 >= 2) ? 14 : 0;
      if (ph == 3) begin
        // back-to-back items into a stalled output so the pipe fills and in_ready drops
        send_gap_max = 0;
        hold_req = 1'b1;
        repeat (80) send_code(random_code());
      end
      repeat (PhaseItems) send_code(random_code());
    end

    drain();
    repeat (DrainCycles) @(posedge clk);
    $display("covered %0d samples over %0d calibration settings,", n_items, n_settings);
    $display("with idle gaps on both sides, a long output hold-off and clamp corners");
    if (mismatches == 0) begin
      $display("divider_adc_to_stroke_core verification clean");
    end else begin
      $display("divider_adc_to_stroke_core verification failed");
    end
    $finish;
  end

endmodule

/* divider_adc_to_stroke_core.f */
rtl/core/dats_pkg.sv
rtl/core/dats_cfg.sv
rtl/core/dats_div.sv
rtl/core/dats_scale.sv
rtl/core/divider_adc_to_stroke_core.sv
rtl/core/dats_checker.sv
test/dats_stroke_checker.sv
test/tb.sv
